### rtl/core/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the trapezoid setpoint profiler.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Configuration register layout
    localparam int                     CFG_TICKS_W  = 12;
    localparam logic [CFG_TICKS_W-1:0] TICKS_RESET  = 12'd250;
    localparam logic [CFG_TICKS_W-1:0] TICKS_MIN    = 12'd3;
    localparam logic                   MODE_RESET   = 1'b0;
    localparam logic                   MODE_LINEAR  = 1'b1;
    localparam int                     APB_ADDR_W   = 3;
    localparam int                     APB_DATA_W   = 32;
    localparam logic                   REG_TICKS    = 1'b0;
    localparam logic                   REG_MODE     = 1'b1;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_EVAL    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Phase codes carried in the output tuser
    localparam logic [1:0] PH_ACCEL    = 2'd0;
    localparam logic [1:0] PH_CRUISE   = 2'd1;
    localparam logic [1:0] PH_DECEL    = 2'd2;
    localparam logic [1:0] PH_FINISHED = 2'd3;

    // Operand widths of the shared multiplier and the divider
    localparam int XW    = 2 * CFG_TICKS_W;   // ratio numerator, up to T^2
    localparam int YW    = XW + 2;            // ratio denominator, up to 4*T^2
    localparam int OPB_W = CFG_TICKS_W + 1;   // second tick operand, up to 2*T

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MX,
        ST_MY,
        ST_MN,
        ST_LOAD,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        KIND_ACCEL,
        KIND_CRUISE,
        KIND_DECEL,
        KIND_LINEAR
    } kind_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/core/tsp_div.sv
// ----------------------------------------------------------------------------
// tsp_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module tsp_div
    import tsp_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 26,
    parameter int QUO_W = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam int AW  = DEN_W + 1 + QUO_W;
    localparam int DCW = $clog2(QUO_W);

    logic [AW-1:0]    acc_reg;
    logic [DCW-1:0]   cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [AW-1:0]    shifted;
    logic [DEN_W:0]   top;
    logic [DEN_W:0]   den_ext;
    logic [AW-1:0]    acc_step;

    // One shift and conditional subtract of the partial remainder
    always_comb begin
        shifted  = {acc_reg[AW-2:0], 1'b0};
        top      = shifted[AW-1:QUO_W];
        den_ext  = {1'b0, divisor};
        acc_step = shifted;
        if (top >= den_ext) begin
            acc_step = {top - den_ext, shifted[QUO_W-1:1], 1'b1};
        end
    end

    // Advance the control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCW'(QUO_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the partial remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= AW'(dividend);
        end else if (busy_reg) begin
            acc_reg <= acc_step;
        end
    end

    assign quotient  = acc_reg[QUO_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/core/trapezoid_setpoint_profiler.sv
// ----------------------------------------------------------------------------
// trapezoid_setpoint_profiler
// Position setpoint generator on a trapezoidal or linear move profile.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser carries the command (tick, evaluate, restart),
//   s_tdata carries target, start position and the active flag. Every
//   transaction produces exactly one output transaction on m_*: the setpoint
//   in m_tdata and the phase in m_tuser.
//   Tick, restart, inactive and past-the-end evaluate transactions pass from
//   acceptance straight to ST_DONE. An evaluate inside the move first takes
//   three passes through the shared multiplier, then the bit-serial divider
//   retiring one quotient bit per cycle, then a saturating add. m_tvalid
//   rises when the item leaves ST_DONE; s_tready is low for the whole item
//   and returns in the same cycle, so no new item is taken before the last
//   one has left ST_DONE.
//   A result waiting in the output register does not block acceptance; a
//   finished item waits in its last step until the output register frees.
//   Reset (aresetn low, synchronous) clears the tick counter, all held end
//   positions and the last setpoint, loads profile_ticks = 250 and the
//   trapezoid mode, and empties the output register.
//   Configuration goes through the APB port; the user must write it only
//   while no transaction is in work, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module trapezoid_setpoint_profiler
    import tsp_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int FRACTION_BITS = 16,
    parameter int TICK_BITS     = 12,
    localparam int S_TDATA_W    = ((2 * POSITION_BITS + 1 + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((POSITION_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: target_position, start_position, active (lowest bit up)
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: command
    input  logic [1:0]            s_tuser,
    // m_tdata: setpoint
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: phase
    output logic [1:0]            m_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int P      = POSITION_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int TB     = TICK_BITS;
    localparam int QW     = P + F;
    localparam int CW     = ((TB > CFG_TICKS_W) ? TB : CFG_TICKS_W) + 2;
    localparam int PROD_W = P + XW;
    localparam int NUM_W  = PROD_W + F;

    // Configuration and profile state
    logic [CFG_TICKS_W-1:0] ticks_reg;
    logic                   mode_reg;
    logic [TB-1:0]          elapsed_reg;
    logic signed [QW-1:0]   accel_end_reg;
    logic signed [QW-1:0]   cruise_end_reg;
    logic signed [QW-1:0]   decel_end_reg;
    logic signed [P-1:0]    last_sp_reg;

    // Sequencer and item registers
    state_t                 state_reg, state_next;
    kind_t                  kind_reg;
    logic                   neg_reg;
    logic [P-1:0]           mag_reg;
    logic signed [P-1:0]    start_reg;
    logic [CFG_TICKS_W-1:0] opa_reg;
    logic [OPB_W-1:0]       opb_reg;
    logic [XW-1:0]          x_reg;
    logic [YW-1:0]          y_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic signed [QW-1:0]   res_q_reg;
    logic                   upd_last_reg;
    logic [1:0]             phase_reg;

    // Output register
    logic                   m_tvalid_reg;
    logic [P-1:0]           m_setpoint_reg;
    logic [1:0]             m_phase_reg;

    // Combinational signals
    logic                   accept;
    logic                   cfg_write;
    logic                   out_free;
    logic [CFG_TICKS_W-1:0] t_eff;
    logic [CW-1:0]          tc, tt_c, three_t, two_tt, w_val;
    logic                   le_third, le_two_thirds, le_end;
    logic signed [P-1:0]    in_tgt, in_st;
    logic                   in_act;
    logic [1:0]             in_cmd;
    logic signed [P:0]      diff;
    logic [P:0]             diff_mag;
    logic                   start_calc;
    logic [TB-1:0]          el_after;
    logic [P-1:0]           mul_a;
    logic [XW-1:0]          mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic                   div_start;
    logic [QW-1:0]          quo;
    div_stat_t              div_stat;
    logic signed [QW-1:0]   sum_base;
    logic signed [QW+1:0]   sum_ext;
    logic signed [QW-1:0]   sum_sat;
    logic signed [QW-1:0]   trunc_adj;
    logic [P-1:0]           trunc_sp;

    function automatic logic [1:0] phase_of(input logic [CW-1:0] t,
                                            input logic [CW-1:0] tt,
                                            input logic          lin);
        logic [CW-1:0] t3;
        logic [1:0]    ph;
        begin
            t3 = (t << 1) + t;
            if (lin) begin
                ph = (t <= tt) ? PH_CRUISE : PH_FINISHED;
            end else if (t3 <= tt) begin
                ph = PH_ACCEL;
            end else if (t3 <= (tt << 1)) begin
                ph = PH_CRUISE;
            end else if (t <= tt) begin
                ph = PH_DECEL;
            end else begin
                ph = PH_FINISHED;
            end
            return ph;
        end
    endfunction

    // Unpack the input transaction
    assign in_tgt = signed'(s_tdata[P-1:0]);
    assign in_st  = signed'(s_tdata[2*P-1:P]);
    assign in_act = s_tdata[2*P];
    assign in_cmd = s_tuser;

    // Profile position of the current tick
    always_comb begin
        t_eff         = (ticks_reg < TICKS_MIN) ? TICKS_MIN : ticks_reg;
        tc            = CW'(elapsed_reg);
        tt_c          = CW'(t_eff);
        three_t       = (tc << 1) + tc;
        two_tt        = tt_c << 1;
        w_val         = three_t - two_tt;
        le_third      = (three_t <= tt_c);
        le_two_thirds = (three_t <= two_tt);
        le_end        = (tc <= tt_c);
        diff          = {in_tgt[P-1], in_tgt} - {in_st[P-1], in_st};
        diff_mag      = diff[P] ? unsigned'(-diff) : unsigned'(diff);
        start_calc    = (in_cmd == CMD_EVAL) && in_act && le_end;
    end

    // Counter value after a tick, restart or other command
    always_comb begin
        case (in_cmd)
            CMD_TICK: begin
                el_after = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
            end
            CMD_RESTART: begin
                el_after = '0;
            end
            default: begin
                el_after = elapsed_reg;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = start_calc ? ST_MX : ST_DONE;
                end
            end
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MN;
            ST_MN:   state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done && !div_stat.busy) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider start, multiplier operands
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_LOAD);
        out_free  = !m_tvalid_reg || m_tready;
        mul_a     = P'(opa_reg);
        mul_b     = XW'(opb_reg);
        case (state_reg)
            ST_MY: begin
                mul_a = P'(t_eff);
                if (kind_reg == KIND_ACCEL || kind_reg == KIND_DECEL) begin
                    mul_b = XW'(t_eff);
                end else begin
                    mul_b = XW'(1);
                end
            end
            ST_MN: begin
                mul_a = mag_reg;
                mul_b = x_reg;
            end
            default: begin
                mul_a = P'(opa_reg);
                mul_b = XW'(opb_reg);
            end
        endcase
    end

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    assign accept    = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Saturating add of the phase travel onto the held base
    always_comb begin
        case (kind_reg)
            KIND_CRUISE: sum_base = accel_end_reg;
            KIND_DECEL:  sum_base = cruise_end_reg;
            default:     sum_base = signed'({start_reg, {F{1'b0}}});
        endcase
        if (neg_reg) begin
            sum_ext = signed'({{2{sum_base[QW-1]}}, sum_base}) - signed'({2'b00, quo});
        end else begin
            sum_ext = signed'({{2{sum_base[QW-1]}}, sum_base}) + signed'({2'b00, quo});
        end
        if (sum_ext > signed'({3'b000, {(QW-1){1'b1}}})) begin
            sum_sat = signed'({1'b0, {(QW-1){1'b1}}});
        end else if (sum_ext < signed'({3'b111, {(QW-1){1'b0}}})) begin
            sum_sat = signed'({1'b1, {(QW-1){1'b0}}});
        end else begin
            sum_sat = sum_ext[QW-1:0];
        end
    end

    // Drop the fraction, rounding toward zero
    always_comb begin
        trunc_adj = res_q_reg;
        if (res_q_reg[QW-1]) begin
            trunc_adj = res_q_reg + signed'({{(QW-F){1'b0}}, {F{1'b1}}});
        end
        trunc_sp = trunc_adj[QW-1:F];
    end

    // Control state and profile state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ticks_reg      <= TICKS_RESET;
            mode_reg       <= MODE_RESET;
            elapsed_reg    <= '0;
            accel_end_reg  <= '0;
            cruise_end_reg <= '0;
            decel_end_reg  <= '0;
            last_sp_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_write) begin
                if (paddr[2] == REG_MODE) begin
                    mode_reg <= pwdata[0];
                end else begin
                    ticks_reg <= pwdata[CFG_TICKS_W-1:0];
                end
            end

            if (accept) begin
                if (in_cmd == CMD_EVAL && in_act) begin
                    if (!le_end) begin
                        elapsed_reg <= tt_c[TB-1:0];
                    end
                end else begin
                    elapsed_reg <= el_after;
                end
            end

            if (state_reg == ST_SUM) begin
                case (kind_reg)
                    KIND_CRUISE: cruise_end_reg <= sum_sat;
                    KIND_DECEL:  decel_end_reg  <= sum_sat;
                    default:     accel_end_reg  <= sum_sat;
                endcase
            end

            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (upd_last_reg) begin
                    last_sp_reg <= signed'(trunc_sp);
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item capture and datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg      <= diff[P];
            mag_reg      <= diff_mag[P-1:0];
            start_reg    <= in_st;
            upd_last_reg <= 1'b0;
            phase_reg    <= phase_of(CW'(el_after), tt_c, mode_reg);
            kind_reg     <= KIND_LINEAR;
            opa_reg      <= tc[CFG_TICKS_W-1:0];
            opb_reg      <= OPB_W'(1);
            if (in_cmd == CMD_EVAL && in_act) begin
                upd_last_reg <= 1'b1;
                if (!le_end) begin
                    // past the end: repeat the held final position
                    phase_reg <= PH_FINISHED;
                    res_q_reg <= (mode_reg == MODE_LINEAR) ? accel_end_reg : decel_end_reg;
                end else if (mode_reg == MODE_LINEAR) begin
                    phase_reg <= PH_CRUISE;
                end else if (le_third) begin
                    kind_reg  <= KIND_ACCEL;
                    phase_reg <= PH_ACCEL;
                    opb_reg   <= OPB_W'(tc[CFG_TICKS_W-1:0]);
                end else if (le_two_thirds) begin
                    kind_reg  <= KIND_CRUISE;
                    phase_reg <= PH_CRUISE;
                    opa_reg   <= CFG_TICKS_W'(three_t - tt_c);
                end else begin
                    kind_reg  <= KIND_DECEL;
                    phase_reg <= PH_DECEL;
                    opa_reg   <= w_val[CFG_TICKS_W-1:0];
                    opb_reg   <= OPB_W'(two_tt - w_val);
                end
            end
        end

        case (state_reg)
            ST_MX: begin
                prod_reg <= mul_p;
            end
            ST_MY: begin
                if (kind_reg == KIND_ACCEL) begin
                    x_reg <= {prod_reg[XW-4:0], 3'b000} + prod_reg[XW-1:0];
                end else begin
                    x_reg <= prod_reg[XW-1:0];
                end
                prod_reg <= mul_p;
            end
            ST_MN: begin
                case (kind_reg)
                    KIND_CRUISE: y_reg <= {prod_reg[YW-2:0], 1'b0};
                    KIND_LINEAR: y_reg <= prod_reg[YW-1:0];
                    default:     y_reg <= {prod_reg[YW-3:0], 2'b00};
                endcase
                prod_reg <= mul_p;
            end
            ST_SUM: begin
                res_q_reg <= sum_sat;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_setpoint_reg <= upd_last_reg ? trunc_sp : unsigned'(last_sp_reg);
                    m_phase_reg    <= phase_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Shared divider for the phase travel
    tsp_div #(
        .NUM_W (NUM_W),
        .DEN_W (YW),
        .QUO_W (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({prod_reg, {F{1'b0}}}),
        .divisor  (y_reg),
        .quotient (quo),
        .stat     (div_stat)
    );

    // Register read back
    always_comb begin
        if (paddr[2] == REG_MODE) begin
            prdata = APB_DATA_W'(mode_reg);
        end else begin
            prdata = APB_DATA_W'(ticks_reg);
        end
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_setpoint_reg);
    assign m_tuser  = m_phase_reg;

endmodule

### rtl/core/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the trapezoid setpoint profiler, bound to the top.
// ----------------------------------------------------------------------------
module tsp_checker #(
    parameter int TDATA_W = 24
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser
);

    // Drop ready for the cycle after a transaction is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Hold a stalled result
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // No result appears without an input transaction
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid && !m_tvalid |=> !m_tvalid)
        else $error("result without input transaction");

    // Come out of reset empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind trapezoid_setpoint_profiler tsp_checker #(
    .TDATA_W (M_TDATA_W)
) u_tsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/setpoint_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// setpoint_checker
// Watches the configuration port and both streams of the setpoint profiler.
// Every accepted input transaction is run through a cycle-free profile
// predictor, and every output transaction is compared with the oldest
// predicted setpoint and phase.
// ----------------------------------------------------------------------------
module setpoint_checker
    import tsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata: target_position, start_position, active (lowest bit up)
    input  logic [55:0]           s_tdata,
    // s_tuser: command
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: setpoint
    input  logic [23:0]           m_tdata,
    // m_tuser: phase
    input  logic [1:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    pending
);

    localparam int     POS_W    = 24;
    localparam int     FRAC_W   = 16;
    localparam longint Q_HI     = (longint'(1) << (POS_W - 1 + FRAC_W)) - 1;
    localparam longint Q_LO     = -Q_HI - 1;
    localparam longint INCR_CAP = longint'(1) << 58;

    localparam logic [APB_ADDR_W-1:0] TICKS_ADDR = {REG_TICKS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR  = {REG_MODE, 2'b00};

    typedef struct packed {
        logic [POS_W-1:0] setpoint;
        logic [1:0]       phase;
    } setpoint_t;

    setpoint_t               expected_setpoints[$];
    logic [CFG_TICKS_W-1:0]  cfg_ticks;
    logic                    cfg_mode;
    logic [CFG_TICKS_W-1:0]  elapsed;
    longint                  accel_q;
    longint                  cruise_q;
    longint                  decel_q;
    logic signed [POS_W-1:0] last_sp;
    int                      results_seen;

    // floor(num * mult / den) on a wide product, all ones when it overflows 64 bits
    function automatic longint unsigned scaled_ratio(input longint unsigned num,
                                                     input longint unsigned mult,
                                                     input longint unsigned den);
        logic [127:0] quot;
        quot = ({64'd0, num} * {64'd0, mult}) / {64'd0, den};
        return (quot[127:64] != '0) ? '1 : quot[63:0];
    endfunction

    // Add or subtract a travel increment, clamped to the position range
    function automatic longint sat_add(input longint base, input logic neg,
                                       input longint unsigned inc);
        longint incr;
        longint sum;
        incr = (inc > INCR_CAP) ? INCR_CAP : longint'(inc);
        sum  = neg ? base - incr : base + incr;
        if (sum > Q_HI) return Q_HI;
        if (sum < Q_LO) return Q_LO;
        return sum;
    endfunction

    // Advance the profile state by one input transaction and return its result
    function automatic setpoint_t step_profile(input logic [1:0] cmd,
                                               input logic signed [POS_W-1:0] tgt,
                                               input logic signed [POS_W-1:0] st,
                                               input logic act);
        longint unsigned span;
        longint unsigned t;
        longint unsigned w;
        longint unsigned mag_q;
        longint unsigned e;
        longint          delta;
        longint          base;
        longint          held;
        logic            neg;
        logic [1:0]      ph;

        span = 64'((cfg_ticks < TICKS_MIN) ? TICKS_MIN : cfg_ticks);
        t    = 64'(elapsed);

        // Counter commands; a tick saturates at all ones
        if (cmd == CMD_TICK && elapsed != '1) begin
            elapsed = elapsed + 1'b1;
        end else if (cmd == CMD_RESTART) begin
            elapsed = '0;
        end

        if (cmd == CMD_EVAL && act) begin
            delta = longint'(tgt) - longint'(st);
            neg   = delta < 0;
            mag_q = longint'(neg ? -delta : delta) << FRAC_W;
            base  = longint'(st) * (longint'(1) << FRAC_W);
            if (cfg_mode == MODE_LINEAR) begin
                if (t <= span) begin
                    accel_q = sat_add(base, neg, scaled_ratio(mag_q, t, span));
                    ph = PH_CRUISE;
                end else begin
                    elapsed = span[CFG_TICKS_W-1:0];
                    ph = PH_FINISHED;
                end
                held = accel_q;
            end else if (3 * t <= span) begin
                accel_q = sat_add(base, neg, scaled_ratio(9 * mag_q, t * t, 4 * span * span));
                held = accel_q;
                ph = PH_ACCEL;
            end else if (3 * t <= 2 * span) begin
                cruise_q = sat_add(accel_q, neg, scaled_ratio(mag_q, 3 * t - span, 2 * span));
                held = cruise_q;
                ph = PH_CRUISE;
            end else if (t <= span) begin
                w = 3 * t - 2 * span;
                decel_q = sat_add(cruise_q, neg,
                                  scaled_ratio(mag_q, w * (2 * span - w), 4 * span * span));
                held = decel_q;
                ph = PH_DECEL;
            end else begin
                elapsed = span[CFG_TICKS_W-1:0];
                held = decel_q;
                ph = PH_FINISHED;
            end
            // Truncate toward zero
            last_sp = POS_W'((held >= 0) ? held >>> FRAC_W : -((-held) >>> FRAC_W));
        end else begin
            // Repeat the last setpoint with the phase the counter implies
            e = 64'(elapsed);
            if (cfg_mode == MODE_LINEAR) begin
                ph = (e <= span) ? PH_CRUISE : PH_FINISHED;
            end else if (3 * e <= span) begin
                ph = PH_ACCEL;
            end else if (3 * e <= 2 * span) begin
                ph = PH_CRUISE;
            end else if (e <= span) begin
                ph = PH_DECEL;
            end else begin
                ph = PH_FINISHED;
            end
        end
        return '{setpoint: last_sp, phase: ph};
    endfunction

    task automatic flag_result(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Track configuration, compare results, then queue new predictions
    always @(posedge aclk) begin
        setpoint_t got;
        setpoint_t want;
        if (!aresetn) begin
            cfg_ticks    = TICKS_RESET;
            cfg_mode     = MODE_RESET;
            elapsed      = '0;
            accel_q      = 0;
            cruise_q     = 0;
            decel_q      = 0;
            last_sp      = '0;
            results_seen = 0;
            expected_setpoints.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == TICKS_ADDR) begin
                    cfg_ticks = pwdata[CFG_TICKS_W-1:0];
                end else if (paddr == MODE_ADDR) begin
                    cfg_mode = pwdata[0];
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{setpoint: m_tdata, phase: m_tuser};
                if (expected_setpoints.size() == 0) begin
                    flag_result($sformatf("result %0d arrived with nothing expected: %0d/%0d",
                                          results_seen, $signed(got.setpoint), got.phase));
                end else begin
                    want = expected_setpoints.pop_front();
                    if (got.setpoint != want.setpoint || got.phase != want.phase) begin
                        flag_result($sformatf(
                            "result %0d setpoint/phase: expected %0d/%0d, got %0d/%0d",
                            results_seen, $signed(want.setpoint), want.phase,
                            $signed(got.setpoint), got.phase));
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                expected_setpoints.push_back(step_profile(s_tuser, $signed(s_tdata[23:0]),
                                                          $signed(s_tdata[47:24]),
                                                          s_tdata[48]));
            end
        end
        pending <= expected_setpoints.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the trapezoid setpoint profiler. Runs a directed pass over
// the profile boundaries and position extremes, a back-to-back tick burst,
// then randomized moves over many profile lengths in both modes, with
// random gaps and stalls on both streams. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import tsp_pkg::*;

    localparam int S_TDATA_W      = 56;
    localparam int M_TDATA_W      = 24;
    localparam int RANDOM_ITEMS   = 720;
    localparam int PHASE_ITEMS    = 90;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int IDLE_LIMIT     = 3000;
    localparam int BURST_TICKS    = 40;

    localparam logic [1:0]             CMD_UNUSED = 2'd3;
    localparam logic [CFG_TICKS_W-1:0] TICKS_TOP  = '1;
    localparam logic [23:0]            POS_MAX    = 24'h7FFFFF;
    localparam logic [23:0]            POS_MIN    = 24'h800000;

    localparam logic [APB_ADDR_W-1:0] TICKS_ADDR = {REG_TICKS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR  = {REG_MODE, 2'b00};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int idle_cycles = 0;
    int sent_items  = 0;
    int cur_span;
    bit fast_send   = 1'b0;
    bit fast_recv   = 1'b0;
    bit hold_req    = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    trapezoid_setpoint_profiler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    setpoint_checker u_setpoint_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input logic [1:0] cmd, input logic [23:0] tgt,
                             input logic [23:0] st, input logic act);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, act, st, tgt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    // Random payload for commands that ignore the positions
    task automatic send_filler(input logic [1:0] cmd);
        send_item(cmd, 24'($urandom), 24'($urandom), 1'($urandom));
    endtask

    // Drop valid, wait for every outstanding result, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, access cycle, then release the bus
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_TICKS_W-1:0] ticks, input logic mode);
        settle();
        apb_write(TICKS_ADDR, APB_DATA_W'(ticks));
        apb_write(MODE_ADDR, APB_DATA_W'(mode));
        cur_span = (ticks < TICKS_MIN) ? TICKS_MIN : ticks;
    endtask

    // One move: restart, then ticks and evaluates past the end of the profile,
    // with an occasional stray command mixed in
    task automatic run_move();
        logic [23:0] st;
        logic [23:0] tgt;
        int          ticks_sent;
        int          goal;
        int          roll;
        st = 24'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                tgt = st + 24'($urandom_range(0, 400)) - 24'd200;
            end
            1: begin
                tgt = st;
            end
            default: begin
                tgt = 24'($urandom);
            end
        endcase
        send_filler(CMD_RESTART);
        goal = cur_span + $urandom_range(1, 3);
        ticks_sent = 0;
        while (ticks_sent < goal) begin
            roll = $urandom_range(0, 19);
            if (roll < 11) begin
                send_filler(CMD_TICK);
                ticks_sent++;
            end else if (roll < 19) begin
                send_item(CMD_EVAL, tgt, st, roll != 18);
            end else begin
                send_filler(2'($urandom_range(CMD_TICK, CMD_UNUSED)));
            end
        end
        send_item(CMD_EVAL, tgt, st, 1'b1);
    endtask

    // Result side: random stall per transaction, or a long hold when requested
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = hold_req ? HOLD_CYCLES : (fast_recv ? 0 : $urandom_range(0, 15));
            hold_req = 1'b0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   span_pick;
        int   phase_idx;
        int   random_base;
        int   phase_base;
        logic mode_pick;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_span = TICKS_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: full-range move, stray command, inactive evaluate
        send_item(CMD_EVAL, POS_MAX, POS_MIN, 1'b1);
        send_filler(CMD_TICK);
        send_item(CMD_EVAL, POS_MAX, POS_MIN, 1'b1);
        send_filler(CMD_UNUSED);
        send_item(CMD_EVAL, 24'($urandom), 24'($urandom), 1'b0);

        // Shortest profile: walk every phase boundary of a full downward move
        configure(TICKS_MIN, MODE_RESET);
        send_filler(CMD_RESTART);
        send_item(CMD_EVAL, POS_MIN, POS_MAX, 1'b1);
        repeat (4) begin
            send_filler(CMD_TICK);
            send_item(CMD_EVAL, POS_MIN, POS_MAX, 1'b1);
        end
        send_item(CMD_EVAL, 24'd12345, 24'd12345, 1'b1);

        // Drive the held end positions into the upper clamp
        send_filler(CMD_RESTART);
        send_filler(CMD_TICK);
        send_item(CMD_EVAL, POS_MAX, POS_MAX, 1'b1);
        send_filler(CMD_TICK);
        send_item(CMD_EVAL, POS_MAX, POS_MIN, 1'b1);
        send_filler(CMD_TICK);
        send_item(CMD_EVAL, POS_MIN, 24'd0, 1'b1);
        send_filler(CMD_UNUSED);

        // Period below the minimum, in both modes
        configure(12'd0, MODE_RESET);
        run_move();
        run_move();
        configure(12'd2, MODE_LINEAR);
        run_move();
        run_move();

        // Longest period: back-to-back ticks with no gaps or stalls
        configure(TICKS_TOP, MODE_RESET);
        fast_send = 1'b1;
        fast_recv = 1'b1;
        send_filler(CMD_RESTART);
        repeat (BURST_TICKS) send_filler(CMD_TICK);
        send_item(CMD_EVAL, 24'($urandom), 24'($urandom), 1'b1);
        send_filler(CMD_TICK);
        send_item(CMD_EVAL, 24'($urandom), 24'($urandom), 1'b1);
        send_filler(CMD_RESTART);
        send_filler(CMD_TICK);
        send_item(CMD_EVAL, 24'($urandom), 24'($urandom), 1'b1);
        fast_send = 1'b0;
        fast_recv = 1'b0;

        configure(TICKS_TOP, MODE_LINEAR);
        send_filler(CMD_RESTART);
        repeat (4) begin
            send_filler(CMD_TICK);
            send_item(CMD_EVAL, POS_MAX, POS_MIN, 1'b1);
        end

        // Random moves over many profile settings
        random_base = sent_items;
        phase_idx = 0;
        while (sent_items - random_base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: begin
                    span_pick = $urandom_range(0, 2);
                end
                1: begin
                    span_pick = $urandom_range(31, 60);
                end
                default: begin
                    span_pick = $urandom_range(3, 30);
                end
            endcase
            mode_pick = 1'($urandom_range(0, 1));
            configure(CFG_TICKS_W'(span_pick), mode_pick);
            fast_send = ($urandom_range(0, 3) == 0);
            fast_recv = ($urandom_range(0, 3) == 0);
            if (phase_idx == 1) begin
                // Long result hold while items keep coming, so the block backs up
                fast_send = 1'b1;
                fast_recv = 1'b0;
                hold_req  = 1'b1;
            end
            phase_base = sent_items;
            if (phase_idx == 2) begin
                // Pause the sender until everything has drained
                run_move();
                settle();
            end
            while (sent_items - phase_base < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) begin
                    run_move();
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        send_filler(2'($urandom_range(CMD_TICK, CMD_UNUSED)));
                    end
                end
            end
            phase_idx++;
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tsp_pkg.sv
rtl/core/tsp_div.sv
rtl/core/trapezoid_setpoint_profiler.sv
rtl/core/tsp_checker.sv
sim/setpoint_checker.sv
sim/tb_top.sv
